// ===== hw/rtl/utbs_pkg.sv =====
package utbs_pkg;

   localparam int MAX_PATTERN_CHARS = 32;
   localparam int OFFSET_BITS       = 40;
   localparam int DATA_BITS         = 8;
   localparam int CFG_BITS          = 64;
   localparam int PATTERN_REGS      = 4;
   localparam int PATTERN_BITS      = PATTERN_REGS * CFG_BITS;
   localparam int LEN_BITS          = 6;
   localparam int WIN_DEPTH         = 2 * MAX_PATTERN_CHARS;
   localparam int FILL_BITS         = $clog2(WIN_DEPTH + 1);
   localparam int CSR_INDEX_BITS    = 3;
   localparam int QUEUE_DEPTH       = 4;
   localparam int QPTR_BITS         = $clog2(QUEUE_DEPTH);
   localparam int QCNT_BITS         = $clog2(QUEUE_DEPTH + 1);

   localparam logic [DATA_BITS-1:0] WIDE_FILL = 8'h00;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_PAT_LOW      = 3'd0,
      CSR_PAT_MID_LOW  = 3'd1,
      CSR_PAT_MID_HIGH = 3'd2,
      CSR_PAT_HIGH     = 3'd3,
      CSR_LENGTH       = 3'd4,
      CSR_LIMIT        = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic [PATTERN_BITS-1:0] pattern;
      logic [LEN_BITS-1:0]     length;
      logic [OFFSET_BITS-1:0]  limit;
   } cfg_type;

   typedef struct packed {
      logic [DATA_BITS-1:0]   data_byte;
      logic [OFFSET_BITS-1:0] byte_offset;
      logic                   final_byte;
      logic                   skip;
   } item_type;

endpackage

// ===== hw/rtl/utbs_csr.sv =====
module utbs_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [utbs_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [utbs_pkg::CFG_BITS-1:0]       csr_wdata,
   output utbs_pkg::cfg_type                   cfg
);
   import utbs_pkg::*;

   cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_PAT_LOW:      cfg_in.pattern[0*CFG_BITS +: CFG_BITS] = csr_wdata;
            CSR_PAT_MID_LOW:  cfg_in.pattern[1*CFG_BITS +: CFG_BITS] = csr_wdata;
            CSR_PAT_MID_HIGH: cfg_in.pattern[2*CFG_BITS +: CFG_BITS] = csr_wdata;
            CSR_PAT_HIGH:     cfg_in.pattern[3*CFG_BITS +: CFG_BITS] = csr_wdata;
            CSR_LENGTH:       cfg_in.length = csr_wdata[LEN_BITS-1:0];
            CSR_LIMIT:        cfg_in.limit  = csr_wdata[OFFSET_BITS-1:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pattern <= '0;
         cfg_ff.length  <= LEN_BITS'(1);
         cfg_ff.limit   <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

endmodule

// ===== hw/rtl/utbs_front.sv =====
module utbs_front (
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [utbs_pkg::DATA_BITS-1:0]   req_data_byte,
   input  logic [utbs_pkg::OFFSET_BITS-1:0] req_byte_offset,
   input  logic                             req_final_byte,
   input  utbs_pkg::cfg_type                cfg,
   input  logic                             queue_full,
   output logic                             push,
   output utbs_pkg::item_type               push_item
);
   import utbs_pkg::*;

   // mark bytes at or above a nonzero limit for skipping
   always_comb begin
      push_item.data_byte   = req_data_byte;
      push_item.byte_offset = req_byte_offset;
      push_item.final_byte  = req_final_byte;
      push_item.skip        = (cfg.limit != '0) && (req_byte_offset >= cfg.limit);
   end

   assign req_stall = queue_full;
   assign push      = req_valid && !queue_full;

endmodule

// ===== hw/rtl/utbs_queue.sv =====
module utbs_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  utbs_pkg::item_type push_item,
   input  logic               pop,
   output utbs_pkg::item_type pop_item,
   output logic               queue_full,
   output logic               queue_empty
);
   import utbs_pkg::*;

   item_type               q_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_BITS-1:0]   count_ff, count_in;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QPTR_BITS'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + QPTR_BITS'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + QCNT_BITS'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QCNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= push_item;
      end
   end

   assign pop_item    = q_ff[rd_ptr_ff];
   assign queue_full  = (count_ff == QCNT_BITS'(QUEUE_DEPTH));
   assign queue_empty = (count_ff == '0);

endmodule

// ===== hw/rtl/utbs_back.sv =====
module utbs_back (
   input  logic                             clock,
   input  logic                             reset,
   input  utbs_pkg::cfg_type                cfg,
   input  utbs_pkg::item_type               pop_item,
   input  logic                             queue_empty,
   output logic                             pop,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic                             rsp_found,
   output logic [utbs_pkg::OFFSET_BITS-1:0] rsp_match_offset
);
   import utbs_pkg::*;

   logic [DATA_BITS-1:0]   win_ff [WIN_DEPTH];
   logic [DATA_BITS-1:0]   win_in [WIN_DEPTH];
   logic [DATA_BITS-1:0]   win_shift [WIN_DEPTH];
   logic [FILL_BITS-1:0]   fill_ff, fill_in, fill_inc;
   logic                   done_ff, done_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   found_ff, found_in;
   logic [OFFSET_BITS-1:0] offset_ff, offset_in;
   logic [LEN_BITS-1:0]    eff_len;
   logic [MAX_PATTERN_CHARS-1:0] lane_ok;
   logic                   hit;
   logic                   result;

   always_comb begin
      eff_len = cfg.length;
      if (cfg.length == '0) begin
         eff_len = LEN_BITS'(1);
      end else if (cfg.length > LEN_BITS'(MAX_PATTERN_CHARS)) begin
         eff_len = LEN_BITS'(MAX_PATTERN_CHARS);
      end

      win_shift[0] = pop_item.data_byte;
      for (int i = 1; i < WIN_DEPTH; i++) begin
         win_shift[i] = win_ff[i-1];
      end

      fill_inc = (fill_ff == FILL_BITS'(WIN_DEPTH)) ? fill_ff : fill_ff + FILL_BITS'(1);

      // compare each widened character against the shifted window
      for (int i = 0; i < MAX_PATTERN_CHARS; i++) begin
         lane_ok[i] = ((win_shift[2*i] == cfg.pattern[8*i +: 8])
                       && (win_shift[2*i+1] == WIDE_FILL))
                      || !(LEN_BITS'(i) < eff_len);
      end
      hit = (&lane_ok) && (fill_inc >= FILL_BITS'({eff_len, 1'b0}));

      pop = !queue_empty && (!rsp_valid_ff || !rsp_stall);

      win_in       = win_ff;
      fill_in      = fill_ff;
      done_in      = done_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      found_in     = found_ff;
      offset_in    = offset_ff;
      result       = 1'b0;

      if (pop) begin
         if (!done_ff) begin
            if (!pop_item.skip) begin
               win_in  = win_shift;
               fill_in = fill_inc;
               if (hit) begin
                  result    = 1'b1;
                  found_in  = 1'b1;
                  offset_in = pop_item.byte_offset;
                  done_in   = 1'b1;
               end
            end
            if (!result && pop_item.final_byte) begin
               result    = 1'b1;
               found_in  = 1'b0;
               offset_in = '0;
            end
         end
         if (pop_item.final_byte) begin
            fill_in = '0;
            done_in = 1'b0;
         end
         if (result) begin
            rsp_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff      <= '0;
         done_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         fill_ff      <= fill_in;
         done_ff      <= done_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      win_ff    <= win_in;
      found_ff  <= found_in;
      offset_ff <= offset_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_found        = found_ff;
   assign rsp_match_offset = offset_ff;

endmodule

// ===== hw/rtl/utf16_tag_backward_search_core.sv =====
// channel  valid       stall / ready  payload
// req      req_valid   req_stall      req_data_byte, req_byte_offset, req_final_byte
// rsp      rsp_valid   rsp_stall      rsp_found, rsp_match_offset
// csr      csr_valid   csr_ready      csr_index, csr_wdata
//
// One word per cycle sustained while req_stall is low; a result reaches rsp once its word has
// passed through the queue and been registered into the back end's rsp registers.
// Throughput is set by the window shift and the 32-lane compare in the back end.
// Synchronous reset clears the window fill, the search state, the queue pointers and
// rsp_valid, and resets the settings; window bytes, queue slots and the result payload are left as they are.
// A four-word queue absorbs up to four input words while a result waits on rsp_stall;
// req_stall rises once the queue is full.
module utf16_tag_backward_search_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [utbs_pkg::DATA_BITS-1:0]      req_data_byte,
   input  logic [utbs_pkg::OFFSET_BITS-1:0]    req_byte_offset,
   input  logic                                req_final_byte,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_found,
   output logic [utbs_pkg::OFFSET_BITS-1:0]    rsp_match_offset,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [utbs_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [utbs_pkg::CFG_BITS-1:0]       csr_wdata
);
   import utbs_pkg::*;

   cfg_type  cfg;
   item_type push_item;
   item_type pop_item;
   logic     push;
   logic     pop;
   logic     queue_full;
   logic     queue_empty;

   utbs_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   utbs_front u_front (
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_data_byte   (req_data_byte),
      .req_byte_offset (req_byte_offset),
      .req_final_byte  (req_final_byte),
      .cfg             (cfg),
      .queue_full      (queue_full),
      .push            (push),
      .push_item       (push_item)
   );

   utbs_queue u_queue (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .push_item   (push_item),
      .pop         (pop),
      .pop_item    (pop_item),
      .queue_full  (queue_full),
      .queue_empty (queue_empty)
   );

   utbs_back u_back (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg),
      .pop_item         (pop_item),
      .queue_empty      (queue_empty),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_found        (rsp_found),
      .rsp_match_offset (rsp_match_offset)
   );

endmodule

// ===== tb/tb.sv =====
module tb;
   import utbs_pkg::*;

   localparam int QUIET_LIMIT = 4000;
   localparam int PHASE_WORDS = 400;
   localparam int TAIL_CYCLES = 6;
   localparam logic [OFFSET_BITS-1:0] OFFSET_MAX = '1;

   typedef struct packed {
      logic                   found;
      logic [OFFSET_BITS-1:0] match_offset;
   } search_report_type;

   typedef enum logic {ROW_BYTE, ROW_SETUP} row_kind_type;

   typedef struct {
      row_kind_type           kind;
      logic [DATA_BITS-1:0]   data_byte;
      logic [OFFSET_BITS-1:0] byte_offset;
      logic                   final_byte;
      bit                     known;
      bit                     known_some;
      search_report_type      known_report;
      logic [PATTERN_BITS-1:0] chars;
      logic [CFG_BITS-1:0]    length_word;
      logic [CFG_BITS-1:0]    limit_word;
   } stim_row_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   logic [DATA_BITS-1:0]      req_data_byte = '0;
   logic [OFFSET_BITS-1:0]    req_byte_offset = '0;
   logic                      req_final_byte = 1'b0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic                      rsp_found;
   logic [OFFSET_BITS-1:0]    rsp_match_offset;
   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index = CSR_PAT_LOW;
   logic [CFG_BITS-1:0]       csr_wdata = '0;

   // typed-in expectation travelling with the word on the bus
   bit                        word_known = 1'b0;
   bit                        word_known_some = 1'b0;
   search_report_type         word_known_report = '0;

   int send_idle_pct = 19;
   int recv_stall_pct = 81;
   int fail_count = 0;
   int words_sent = 0;
   int quiet_cycles = 0;

   // predictor state
   logic [CFG_BITS-1:0]    tag_regs [PATTERN_REGS] = '{default: '0};
   logic [LEN_BITS-1:0]    tag_len_reg = 6'd1;
   logic [OFFSET_BITS-1:0] skip_limit_reg = '0;
   logic [DATA_BITS-1:0]   window [WIN_DEPTH] = '{default: '0};
   int                     window_count = 0;
   bit                     hit_reported = 1'b0;
   search_report_type      awaited_reports [$];

   // settings the stimulus generator plants tags from
   logic [PATTERN_BITS-1:0] tag_plan_chars = '0;
   int                      tag_plan_len = 1;
   logic [OFFSET_BITS-1:0]  limit_plan = '0;

   stim_row_type            directed_rows [$];

   utf16_tag_backward_search_core i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data_byte    (req_data_byte),
      .req_byte_offset  (req_byte_offset),
      .req_final_byte   (req_final_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_found        (rsp_found),
      .rsp_match_offset (rsp_match_offset),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always #4 clock = ~clock;

   function automatic int effective_length(input logic [LEN_BITS-1:0] len_reg);
      if (len_reg == 0) return 1;
      if (len_reg > MAX_PATTERN_CHARS) return MAX_PATTERN_CHARS;
      return int'(len_reg);
   endfunction

   function automatic void track_search(input logic [DATA_BITS-1:0] data_byte,
                                        input logic [OFFSET_BITS-1:0] byte_offset,
                                        input logic final_byte,
                                        output bit produced,
                                        output search_report_type report);
      bit skip;
      bit hit;
      int len;
      produced = 1'b0;
      report = '0;
      if (!hit_reported) begin
         skip = (skip_limit_reg != 0) && (byte_offset >= skip_limit_reg);
         if (!skip) begin
            for (int k = WIN_DEPTH - 1; k > 0; k--) window[k] = window[k-1];
            window[0] = data_byte;
            if (window_count < WIN_DEPTH) window_count++;
            len = effective_length(tag_len_reg);
            hit = (window_count >= 2 * len);
            for (int k = 0; k < len; k++) begin
               if (window[2*k] != tag_regs[k/8][(k%8)*8 +: 8] || window[2*k+1] != WIDE_FILL)
                  hit = 1'b0;
            end
            if (hit) begin
               produced = 1'b1;
               report.found = 1'b1;
               report.match_offset = byte_offset;
               hit_reported = 1'b1;
            end
         end
         if (!produced && final_byte) begin
            produced = 1'b1;
            report = '0;
         end
      end
      if (final_byte) begin
         window_count = 0;
         hit_reported = 1'b0;
      end
   endfunction

   always @(posedge clock) begin
      search_report_type got;
      search_report_type want;
      search_report_type predicted;
      bit produced;
      if (!reset) begin
         if (csr_valid && csr_ready) begin
            case (csr_index_type'(csr_index))
               CSR_PAT_LOW:      tag_regs[0] = csr_wdata;
               CSR_PAT_MID_LOW:  tag_regs[1] = csr_wdata;
               CSR_PAT_MID_HIGH: tag_regs[2] = csr_wdata;
               CSR_PAT_HIGH:     tag_regs[3] = csr_wdata;
               CSR_LENGTH:       tag_len_reg = csr_wdata[LEN_BITS-1:0];
               CSR_LIMIT:        skip_limit_reg = csr_wdata[OFFSET_BITS-1:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            track_search(req_data_byte, req_byte_offset, req_final_byte, produced, predicted);
            if (word_known) begin
               produced = word_known_some;
               predicted = word_known_report;
            end
            if (produced) awaited_reports.insert(awaited_reports.size(), predicted);
         end
         if (rsp_valid && !rsp_stall) begin
            got.found = rsp_found;
            got.match_offset = rsp_match_offset;
            if (awaited_reports.size() == 0) begin
               fail_count++;
               $display("%0t: unexpected result, expected none, got found=%0b offset=%h",
                        $time, got.found, got.match_offset);
            end else begin
               want = awaited_reports.pop_front();
               if (got.found !== want.found) begin
                  fail_count++;
                  $display("%0t: found expected %0b, got %0b", $time, want.found, got.found);
               end
               if (got.match_offset !== want.match_offset) begin
                  fail_count++;
                  $display("%0t: match_offset expected %h, got %h",
                           $time, want.match_offset, got.match_offset);
               end
            end
         end
      end
   end

   always @(posedge clock) rsp_stall <= ($urandom_range(99) < recv_stall_pct);

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic stim_row_type byte_row(input logic [DATA_BITS-1:0] data_byte,
                                             input logic [OFFSET_BITS-1:0] byte_offset,
                                             input logic final_byte);
      stim_row_type row;
      row = '{kind: ROW_BYTE, default: '0};
      row.kind = ROW_BYTE;
      row.data_byte = data_byte;
      row.byte_offset = byte_offset;
      row.final_byte = final_byte;
      return row;
   endfunction

   function automatic stim_row_type known_row(input logic [DATA_BITS-1:0] data_byte,
                                              input logic [OFFSET_BITS-1:0] byte_offset,
                                              input logic final_byte,
                                              input bit some,
                                              input logic found,
                                              input logic [OFFSET_BITS-1:0] match_offset);
      stim_row_type row;
      row = byte_row(data_byte, byte_offset, final_byte);
      row.known = 1'b1;
      row.known_some = some;
      row.known_report.found = found;
      row.known_report.match_offset = match_offset;
      return row;
   endfunction

   function automatic stim_row_type setup_row(input logic [PATTERN_BITS-1:0] chars,
                                              input logic [CFG_BITS-1:0] length_word,
                                              input logic [CFG_BITS-1:0] limit_word);
      stim_row_type row;
      row = '{kind: ROW_SETUP, default: '0};
      row.kind = ROW_SETUP;
      row.chars = chars;
      row.length_word = length_word;
      row.limit_word = limit_word;
      return row;
   endfunction

   function automatic void add_row(input stim_row_type row);
      directed_rows.insert(directed_rows.size(), row);
   endfunction

   function automatic logic [DATA_BITS-1:0] plan_char(input int k);
      return tag_plan_chars[k*8 +: 8];
   endfunction

   function automatic logic [DATA_BITS-1:0] filler_byte();
      int r;
      r = $urandom_range(99);
      if (r < 30) return WIDE_FILL;
      if (r < 60) return plan_char($urandom_range(tag_plan_len - 1));
      return DATA_BITS'($urandom);
   endfunction

   function automatic logic [OFFSET_BITS-1:0] random_offset();
      return {8'($urandom_range(255)), 32'($urandom)};
   endfunction

   task automatic offer_word(input logic [DATA_BITS-1:0] data_byte,
                             input logic [OFFSET_BITS-1:0] byte_offset,
                             input logic final_byte,
                             input bit known,
                             input bit known_some,
                             input search_report_type known_report);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data_byte <= data_byte;
      req_byte_offset <= byte_offset;
      req_final_byte <= final_byte;
      word_known <= known;
      word_known_some <= known_some;
      word_known_report <= known_report;
      do @(posedge clock); while (req_stall);
      words_sent++;
   endtask

   // hold the input until every awaited result is out and the pipe is empty
   task automatic drain_block();
      req_valid <= 1'b0;
      do @(posedge clock); while (awaited_reports.size() != 0);
      repeat (TAIL_CYCLES) @(posedge clock);
   endtask

   task automatic put_csr(input csr_index_type idx, input logic [CFG_BITS-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic load_settings(input logic [PATTERN_BITS-1:0] chars,
                                input logic [CFG_BITS-1:0] length_word,
                                input logic [CFG_BITS-1:0] limit_word);
      drain_block();
      put_csr(CSR_PAT_LOW, chars[63:0]);
      put_csr(CSR_PAT_MID_LOW, chars[127:64]);
      put_csr(CSR_PAT_MID_HIGH, chars[191:128]);
      put_csr(CSR_PAT_HIGH, chars[255:192]);
      put_csr(CSR_LENGTH, length_word);
      put_csr(CSR_LIMIT, limit_word);
      csr_valid <= 1'b0;
   endtask

   task automatic reconfigure(input int setup_no);
      logic [PATTERN_BITS-1:0] chars;
      logic [LEN_BITS-1:0]     len_reg;
      logic [OFFSET_BITS-1:0]  lim;
      logic [CFG_BITS-1:0]     length_word;
      logic [CFG_BITS-1:0]     limit_word;
      int r;
      for (int w = 0; w < PATTERN_REGS; w++) begin
         r = $urandom_range(9);
         if (r < 4) begin
            for (int b = 0; b < 8; b++) chars[w*64 + b*8 +: 8] = 8'($urandom_range(126, 32));
         end else if (r == 4) begin
            chars[w*64 +: 64] = '0;
         end else if (r == 5) begin
            chars[w*64 +: 64] = '1;
         end else begin
            chars[w*64 +: 64] = {32'($urandom), 32'($urandom)};
         end
      end
      r = $urandom_range(9);
      if (r < 2) len_reg = 6'd1;
      else if (r == 2) len_reg = 6'(MAX_PATTERN_CHARS);
      else if (r == 3) len_reg = '0;
      else if (r == 4) len_reg = 6'($urandom_range(63, 33));
      else len_reg = 6'($urandom_range(12, 1));
      r = $urandom_range(9);
      if (r < 5) lim = '0;
      else if (r < 7) lim = OFFSET_BITS'($urandom_range(200, 1));
      else if (r == 7) lim = OFFSET_MAX;
      else lim = random_offset();
      if (setup_no == 0) begin
         chars = '1;
         len_reg = 6'(MAX_PATTERN_CHARS);
         lim = OFFSET_MAX;
      end else if (setup_no == 1) begin
         chars = '0;
         len_reg = 6'd1;
         lim = '0;
      end
      length_word = CFG_BITS'(len_reg);
      limit_word = CFG_BITS'(lim);
      if ($urandom_range(4) == 0) begin
         length_word = {32'($urandom), 32'($urandom)};
         length_word[LEN_BITS-1:0] = len_reg;
      end
      if ($urandom_range(4) == 0) begin
         limit_word = {32'($urandom), 32'($urandom)};
         limit_word[OFFSET_BITS-1:0] = lim;
      end
      tag_plan_chars = chars;
      tag_plan_len = effective_length(len_reg);
      limit_plan = lim;
      load_settings(chars, length_word, limit_word);
   endtask

   // one search: noise, planted tags (some damaged); broken: random finals
   task automatic run_search(input bit broken);
      logic [DATA_BITS-1:0]   stream [$];
      logic [OFFSET_BITS:0]   wide_start;
      logic [OFFSET_BITS-1:0] start;
      logic                   last;
      int n;
      int pos;
      int r;
      for (int seg = 0; seg < 2; seg++) begin
         repeat ($urandom_range(seg == 0 ? 12 : 8)) stream.insert(stream.size(), filler_byte());
         if ($urandom_range(99) < (seg == 0 ? 70 : 25)) begin
            pos = stream.size();
            for (int k = tag_plan_len - 1; k >= 0; k--) begin
               stream.insert(stream.size(), WIDE_FILL);
               stream.insert(stream.size(), plan_char(k));
            end
            if ($urandom_range(99) < 20) begin
               pos = pos + $urandom_range(2 * tag_plan_len - 1);
               stream[pos] = stream[pos] ^ (8'h01 << $urandom_range(7));
            end
         end
      end
      if (stream.size() == 0) stream.insert(stream.size(), filler_byte());
      n = stream.size();
      if (broken) begin
         foreach (stream[k]) begin
            last = (k == n - 1) ? 1'($urandom_range(1)) : ($urandom_range(11) == 0);
            offer_word(stream[k], random_offset(), last, 1'b0, 1'b0, '0);
         end
      end else begin
         r = $urandom_range(99);
         if (limit_plan != 0 && r < 50) begin
            wide_start = {1'b0, limit_plan} + ($urandom_range(4));
            start = wide_start[OFFSET_BITS] ? OFFSET_MAX : wide_start[OFFSET_BITS-1:0];
         end else if (r < 70) begin
            start = OFFSET_BITS'(n - 1);
         end else if (r < 85) begin
            start = random_offset();
         end else begin
            start = OFFSET_MAX;
         end
         if (start < n - 1) start = OFFSET_BITS'(n - 1);
         foreach (stream[k])
            offer_word(stream[k], start - OFFSET_BITS'(k), k == n - 1, 1'b0, 1'b0, '0);
      end
   endtask

   initial begin
      int phase_end;
      int searches;
      int setups;

      add_row(known_row(8'h41, 40'd100, 1'b0, 1'b0, 1'b0, '0));
      add_row(known_row(8'h00, 40'd99, 1'b0, 1'b0, 1'b0, '0));
      add_row(known_row(8'h00, 40'd98, 1'b0, 1'b1, 1'b1, 40'd98));
      add_row(known_row(8'hFF, 40'd97, 1'b1, 1'b0, 1'b0, '0));
      add_row(known_row(8'hFF, 40'd0, 1'b1, 1'b1, 1'b0, '0));
      add_row(known_row(8'h00, OFFSET_MAX, 1'b0, 1'b0, 1'b0, '0));
      add_row(known_row(8'h00, OFFSET_MAX - 1, 1'b1, 1'b1, 1'b1, OFFSET_MAX - 1));
      add_row(setup_row({{16{4'hA}}, {16{4'h5}}, {16{4'hF}}, 64'h4241}, 64'd2, 64'd50));
      add_row(byte_row(8'h41, 40'd60, 1'b0));
      add_row(byte_row(8'h00, 40'd13, 1'b0));
      add_row(byte_row(8'h42, 40'd12, 1'b0));
      add_row(byte_row(8'h00, 40'd11, 1'b0));
      add_row(byte_row(8'h41, 40'd10, 1'b0));
      add_row(known_row(8'h41, 40'd55, 1'b1, 1'b0, 1'b0, '0));
      add_row(known_row(8'h41, 40'd70, 1'b1, 1'b1, 1'b0, '0));
      add_row(byte_row(8'h00, 40'd1, 1'b0));
      add_row(known_row(8'h41, 40'd0, 1'b1, 1'b1, 1'b0, '0));
      add_row(setup_row({192'd0, 64'h5A}, 64'd0, 64'hFFFF_FF00_0000_0000));
      add_row(byte_row(8'h00, 40'd5, 1'b0));
      add_row(byte_row(8'h5A, 40'd9, 1'b0));
      add_row(byte_row(8'h5A, 40'd3, 1'b1));
      add_row(known_row(8'h5A, 40'd7, 1'b1, 1'b1, 1'b0, '0));

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[k]) begin
         if (directed_rows[k].kind == ROW_SETUP) begin
            load_settings(directed_rows[k].chars, directed_rows[k].length_word,
                          directed_rows[k].limit_word);
         end else begin
            offer_word(directed_rows[k].data_byte, directed_rows[k].byte_offset,
                       directed_rows[k].final_byte, directed_rows[k].known,
                       directed_rows[k].known_some, directed_rows[k].known_report);
         end
      end

      searches = 0;
      setups = 0;
      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 19 : (phase == 1) ? 81 : 0;
         recv_stall_pct = (phase == 0) ? 81 : (phase == 1) ? 19 : 0;
         phase_end = words_sent + PHASE_WORDS;
         while (words_sent < phase_end) begin
            if (searches % 5 == 0) begin
               reconfigure(setups);
               setups++;
            end else if ($urandom_range(11) == 0) begin
               drain_block();
            end
            run_search($urandom_range(9) == 0);
            searches++;
         end
      end

      drain_block();
      if (fail_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

// ===== files.f =====
hw/rtl/utbs_pkg.sv
hw/rtl/utbs_csr.sv
hw/rtl/utbs_front.sv
hw/rtl/utbs_queue.sv
hw/rtl/utbs_back.sv
hw/rtl/utf16_tag_backward_search_core.sv
tb/tb.sv
